// ===== rtl/point_to_cylinder_distance_unit_macros.svh =====
// Assertion macros shared by the point to cylinder distance unit.
`ifndef POINT_TO_CYLINDER_DISTANCE_UNIT_MACROS_SVH
`define POINT_TO_CYLINDER_DISTANCE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define PTCD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define PTCD_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define PTCD_ASSERT(label, clk, rst, prop, msg)
`define PTCD_ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

// ===== rtl/ptcd_pkg.sv =====
// Types, widths and constants of the point to cylinder distance unit.
`timescale 1ns / 1ps

package ptcd_pkg;

   // Field widths.
   localparam int PT_W       = 32;
   localparam int AXIS_W     = 16;
   localparam int RADIUS_W   = 32;
   localparam int DIST_W     = 32;
   localparam int NUM_AXES   = 3;
   localparam int FRAC_SHIFT = 14;

   // Internal datapath widths.
   localparam int DIFF_W     = PT_W + 1;
   localparam int PROD_W     = DIFF_W + AXIS_W;
   localparam int DOT_W      = PROD_W + 2;
   localparam int T_W        = DOT_W - FRAC_SHIFT;
   localparam int TPROD_W    = T_W + AXIS_W;
   localparam int R_W        = TPROD_W - FRAC_SHIFT;
   localparam int Q_W        = R_W + 1;
   localparam int MAG_W      = Q_W;
   localparam int MAG_LO_W   = 32;
   localparam int MAG_HI_W   = MAG_W - MAG_LO_W;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int SUM_W      = SQ_W + 2;
   localparam int TRIAL_W    = SUM_W + 1;
   localparam int ROOT_W     = SUM_W / 2;
   localparam int N_W        = ROOT_W + 1;

   // Rounding offsets for the Q2.14 rescale, one half LSB after the shift.
   localparam logic signed [DOT_W-1:0]   DOT_HALF   = DOT_W'(1) << (FRAC_SHIFT - 1);
   localparam logic signed [TPROD_W-1:0] TPROD_HALF = TPROD_W'(1) << (FRAC_SHIFT - 1);

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_CENTER_X   = 3'd0,
      REG_CENTER_Y   = 3'd1,
      REG_CENTER_Z   = 3'd2,
      REG_AXIS_X     = 3'd3,
      REG_AXIS_Y     = 3'd4,
      REG_AXIS_Z     = 3'd5,
      REG_CYL_RADIUS = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic signed [PT_W-1:0]   center_x;
      logic signed [PT_W-1:0]   center_y;
      logic signed [PT_W-1:0]   center_z;
      logic signed [AXIS_W-1:0] axis_x;
      logic signed [AXIS_W-1:0] axis_y;
      logic signed [AXIS_W-1:0] axis_z;
      logic [RADIUS_W-1:0]      cyl_radius;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      center_x:   '0,
      center_y:   '0,
      center_z:   '0,
      axis_x:     '0,
      axis_y:     '0,
      axis_z:     16'sd16384,
      cyl_radius: '0
   };

   // Handoff from the geometry pipeline to the square root pipeline.
   typedef struct packed {
      logic             valid;
      logic [SUM_W-1:0] sum_sq;
   } front_out_type;

   // Handoff from the square root pipeline to the output stages.
   typedef struct packed {
      logic              valid;
      logic [ROOT_W-1:0] root;
      logic [SUM_W-1:0]  rem;
   } sqrt_out_type;

   // One result beat.
   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              saturated;
   } result_type;

endpackage

// ===== rtl/point_to_cylinder_distance_unit.sv =====
// Top level of the point to cylinder surface distance unit.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req       in         req_tvalid/tready    tdata: point_x, point_y, point_z
// rsp       out        rsp_tvalid/tready    tdata: surface_distance; tuser: saturated
// csr       in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One point is accepted per cycle while req_tready is high; its result passes through 10
// geometry stages, 41 square root stages (one root bit each) and 2 rounding and distance
// stages ahead of the output register.
// Reset is synchronous; it clears all valid bits and loads the register defaults.
// When a result waits and the skid entry is also full, req_tready drops and the whole
// pipeline holds until the consumer takes a beat.

module point_to_cylinder_distance_unit (
   input  logic                                clock,
   input  logic                                reset,
   // Points: [31:0] point_x, [63:32] point_y, [95:64] point_z.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [3*ptcd_pkg::PT_W-1:0]         req_tdata,
   // Results: [31:0] surface_distance.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ptcd_pkg::DIST_W-1:0]         rsp_tdata,
   // Results: [0] saturated.
   output logic                                rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ptcd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ptcd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ptcd_pkg::*;

   cfg_type       cfg_ff;
   logic          advance;
   front_out_type front_out;
   sqrt_out_type  sqrt_out;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_CENTER_X:   cfg_ff.center_x   <= csr_wdata;
            REG_CENTER_Y:   cfg_ff.center_y   <= csr_wdata;
            REG_CENTER_Z:   cfg_ff.center_z   <= csr_wdata;
            REG_AXIS_X:     cfg_ff.axis_x     <= csr_wdata[AXIS_W-1:0];
            REG_AXIS_Y:     cfg_ff.axis_y     <= csr_wdata[AXIS_W-1:0];
            REG_AXIS_Z:     cfg_ff.axis_z     <= csr_wdata[AXIS_W-1:0];
            REG_CYL_RADIUS: cfg_ff.cyl_radius <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A point beat enters whenever the pipeline moves.
   assign req_tready = advance;

   ptcd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .point_x   (req_tdata[PT_W-1:0]),
      .point_y   (req_tdata[2*PT_W-1:PT_W]),
      .point_z   (req_tdata[3*PT_W-1:2*PT_W]),
      .cfg       (cfg_ff),
      .front_out (front_out)
   );

   ptcd_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .din     (front_out),
      .dout    (sqrt_out)
   );

   ptcd_out u_out (
      .clock      (clock),
      .reset      (reset),
      .din        (sqrt_out),
      .cyl_radius (cfg_ff.cyl_radius),
      .rsp_tready (rsp_tready),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/ptcd_front.sv =====
// Geometry pipeline: offset, projection, perpendicular part and its squared norm.
`timescale 1ns / 1ps

module ptcd_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 in_valid,
   input  logic signed [ptcd_pkg::PT_W-1:0]     point_x,
   input  logic signed [ptcd_pkg::PT_W-1:0]     point_y,
   input  logic signed [ptcd_pkg::PT_W-1:0]     point_z,
   input  ptcd_pkg::cfg_type                    cfg,
   output ptcd_pkg::front_out_type              front_out
);
   import ptcd_pkg::*;

   localparam int STAGES = 10;

   logic signed [PT_W-1:0]   pt  [NUM_AXES];
   logic signed [PT_W-1:0]   ctr [NUM_AXES];
   logic signed [AXIS_W-1:0] ax  [NUM_AXES];

   logic [STAGES-1:0] valid_ff;

   // Stage registers, one lane per axis except the single t3_ff and sum10_ff.
   logic signed [DIFF_W-1:0]  d1_ff  [NUM_AXES];
   logic signed [DIFF_W-1:0]  d2_ff  [NUM_AXES];
   logic signed [DIFF_W-1:0]  d3_ff  [NUM_AXES];
   logic signed [DIFF_W-1:0]  d4_ff  [NUM_AXES];
   logic signed [DIFF_W-1:0]  d5_ff  [NUM_AXES];
   logic signed [PROD_W-1:0]  prod2_ff [NUM_AXES];
   logic signed [T_W-1:0]     t3_ff;
   logic signed [TPROD_W-1:0] tp4_ff [NUM_AXES];
   logic signed [R_W-1:0]     r5_ff  [NUM_AXES];
   logic signed [Q_W-1:0]     q6_ff  [NUM_AXES];
   logic [MAG_W-1:0]          mag7_ff [NUM_AXES];
   logic [2*MAG_LO_W-1:0]     ll8_ff [NUM_AXES];
   logic [MAG_W-1:0]          hl8_ff [NUM_AXES];
   logic [2*MAG_HI_W-1:0]     hh8_ff [NUM_AXES];
   logic [SQ_W-1:0]           sq9_ff [NUM_AXES];
   logic [SUM_W-1:0]          sum10_ff;

   // Next values.
   logic signed [DIFF_W-1:0]  d1_in  [NUM_AXES];
   logic signed [PROD_W-1:0]  prod2_in [NUM_AXES];
   logic signed [DOT_W-1:0]   dot_rnd;
   logic signed [TPROD_W-1:0] tp4_in [NUM_AXES];
   logic signed [TPROD_W-1:0] tp_rnd [NUM_AXES];
   logic signed [Q_W-1:0]     q6_in  [NUM_AXES];
   logic [MAG_W-1:0]          mag7_in [NUM_AXES];
   logic [MAG_LO_W-1:0]       mag_lo [NUM_AXES];
   logic [MAG_HI_W-1:0]       mag_hi [NUM_AXES];
   logic [SQ_W-1:0]           sq9_in [NUM_AXES];
   logic [SUM_W-1:0]          sum10_in;

   assign pt[0]  = point_x;
   assign pt[1]  = point_y;
   assign pt[2]  = point_z;
   assign ctr[0] = cfg.center_x;
   assign ctr[1] = cfg.center_y;
   assign ctr[2] = cfg.center_z;
   assign ax[0]  = $signed(cfg.axis_x);
   assign ax[1]  = $signed(cfg.axis_y);
   assign ax[2]  = $signed(cfg.axis_z);

   // Per-lane arithmetic for each stage.
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         d1_in[i]    = DIFF_W'(pt[i]) - DIFF_W'(ctr[i]);
         prod2_in[i] = d1_ff[i] * ax[i];
         tp4_in[i]   = t3_ff * ax[i];
         tp_rnd[i]   = tp4_ff[i] + TPROD_HALF;
         q6_in[i]    = Q_W'(d5_ff[i]) - Q_W'(r5_ff[i]);
         mag7_in[i]  = q6_ff[i][Q_W-1] ? MAG_W'(~q6_ff[i]) + MAG_W'(1) : MAG_W'(q6_ff[i]);
         mag_lo[i]   = mag7_ff[i][MAG_LO_W-1:0];
         mag_hi[i]   = mag7_ff[i][MAG_W-1:MAG_LO_W];
         sq9_in[i]   = {hh8_ff[i], {(2*MAG_LO_W){1'b0}}}
                     + SQ_W'({hl8_ff[i], {(MAG_LO_W+1){1'b0}}})
                     + SQ_W'(ll8_ff[i]);
      end
   end

   // Projection length, rounded to nearest with ties upward.
   assign dot_rnd = DOT_W'(prod2_ff[0]) + DOT_W'(prod2_ff[1]) + DOT_W'(prod2_ff[2])
                  + DOT_HALF;

   // Squared norm of the perpendicular part.
   assign sum10_in = SUM_W'(sq9_ff[0]) + SUM_W'(sq9_ff[1]) + SUM_W'(sq9_ff[2]);

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[STAGES-2:0], in_valid};
      end
   end

   // Datapath registers hold while the pipeline is stalled.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            d1_ff[i]    <= d1_in[i];
            d2_ff[i]    <= d1_ff[i];
            d3_ff[i]    <= d2_ff[i];
            d4_ff[i]    <= d3_ff[i];
            d5_ff[i]    <= d4_ff[i];
            prod2_ff[i] <= prod2_in[i];
            tp4_ff[i]   <= tp4_in[i];
            r5_ff[i]    <= tp_rnd[i][TPROD_W-1:FRAC_SHIFT];
            q6_ff[i]    <= q6_in[i];
            mag7_ff[i]  <= mag7_in[i];
            ll8_ff[i]   <= mag_lo[i] * mag_lo[i];
            hl8_ff[i]   <= mag_hi[i] * mag_lo[i];
            hh8_ff[i]   <= mag_hi[i] * mag_hi[i];
            sq9_ff[i]   <= sq9_in[i];
         end
         t3_ff    <= dot_rnd[DOT_W-1:FRAC_SHIFT];
         sum10_ff <= sum10_in;
      end
   end

   assign front_out.valid  = valid_ff[STAGES-1];
   assign front_out.sum_sq = sum10_ff;

endmodule

// ===== rtl/ptcd_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`include "point_to_cylinder_distance_unit_macros.svh"

module ptcd_sqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  ptcd_pkg::front_out_type din,
   output ptcd_pkg::sqrt_out_type  dout
);
   import ptcd_pkg::*;

   logic [ROOT_W-1:0] valid_ff;
   logic [SUM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   // Valid bits follow the stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[ROOT_W-2:0], din.valid};
      end
   end

   // Stage k decides root bit ROOT_W-1-k against the remainder s - root^2.
   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int B = ROOT_W - 1 - k;

      logic [SUM_W-1:0]   rem_prev;
      logic [ROOT_W-1:0]  root_prev;
      logic [TRIAL_W-1:0] trial;
      logic               take;
      logic [SUM_W-1:0]   rem_in;
      logic [ROOT_W-1:0]  root_in;

      if (k == 0) begin : g_first
         assign rem_prev  = din.sum_sq;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B).
      assign trial   = (TRIAL_W'(root_prev) << (B + 1)) + (TRIAL_W'(1) << (2 * B));
      assign take    = ({1'b0, rem_prev} >= trial);
      assign rem_in  = take ? rem_prev - trial[SUM_W-1:0] : rem_prev;
      assign root_in = take ? (root_prev | (ROOT_W'(1) << B)) : root_prev;

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign dout.valid = valid_ff[ROOT_W-1];
   assign dout.root  = root_ff[ROOT_W-1];
   assign dout.rem   = rem_ff[ROOT_W-1];

   // A finished root leaves a remainder of at most twice the root.
   `PTCD_ASSERT(a_sqrt_rem_bound, clock, reset, valid_ff[ROOT_W-1] |-> (rem_ff[ROOT_W-1] <= {root_ff[ROOT_W-1], 1'b0}), "square root remainder out of bound")

endmodule

// ===== rtl/ptcd_out.sv =====
// Root rounding, distance to the surface, clamping and the output skid stage.
`timescale 1ns / 1ps
`include "point_to_cylinder_distance_unit_macros.svh"

module ptcd_out (
   input  logic                              clock,
   input  logic                              reset,
   input  ptcd_pkg::sqrt_out_type            din,
   input  logic [ptcd_pkg::RADIUS_W-1:0]     cyl_radius,
   input  logic                              rsp_tready,
   output logic                              advance,
   output logic                              rsp_tvalid,
   output logic [ptcd_pkg::DIST_W-1:0]       rsp_tdata,
   output logic                              rsp_tuser
);
   import ptcd_pkg::*;

   logic             n_valid_ff;
   logic [N_W-1:0]   n_ff;
   logic [N_W-1:0]   n_in;
   logic             dist_valid_ff;
   logic [N_W-1:0]   dist_ff;
   logic [N_W-1:0]   dist_in;
   logic             arrive;
   result_type       result_in;
   result_type       rsp_ff;
   result_type       skid_ff;
   logic             rsp_valid_ff;
   logic             skid_valid_ff;

   // The pipeline moves whenever the skid stage is free.
   assign advance = !skid_valid_ff;
   assign arrive  = advance && dist_valid_ff;

   // Round the root to nearest: s > r^2 + r means rem > r.
   assign n_in = N_W'(din.root) + N_W'(din.rem > SUM_W'(din.root));

   // Absolute difference to the radius.
   assign dist_in = (n_ff >= N_W'(cyl_radius)) ? n_ff - N_W'(cyl_radius)
                                               : N_W'(cyl_radius) - n_ff;

   // Clamp to the output range.
   assign result_in.saturated = |dist_ff[N_W-1:DIST_W];
   assign result_in.distance  = result_in.saturated ? DIST_MAX : dist_ff[DIST_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         n_valid_ff    <= 1'b0;
         dist_valid_ff <= 1'b0;
      end else if (advance) begin
         n_valid_ff    <= din.valid;
         dist_valid_ff <= n_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         n_ff    <= n_in;
         dist_ff <= dist_in;
      end
   end

   // Output register with one skid entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_tready) begin
            rsp_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (arrive) begin
         if (!rsp_valid_ff || rsp_tready) begin
            rsp_ff       <= result_in;
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= result_in;
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.distance;
   assign rsp_tuser  = rsp_ff.saturated;

   `PTCD_ASSERT_NEVER(a_skid_without_output, clock, reset, skid_valid_ff && !rsp_valid_ff, "skid entry held while output register is empty")
   `PTCD_ASSERT(a_skid_drains, clock, reset, skid_valid_ff && rsp_tready |=> rsp_valid_ff && !skid_valid_ff, "skid entry did not move to the output register")
   `PTCD_ASSERT(a_clamp_value, clock, reset, rsp_valid_ff && rsp_ff.saturated |-> rsp_ff.distance == DIST_MAX, "saturated result not clamped to full scale")

endmodule
